>>> sv/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared widths and operation / status codes for the ordered record list.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int KIND_W = 3;
  localparam int POS_W  = 7;
  localparam int KEY_W  = 64;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND_NAME  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_IDENT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COUNT      = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS   = 2'd3;

endpackage

>>> sv/ordered_list_insert_remove_search.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search
// Ordered list of up to DEPTH records (identifier key, name key) with
// positional insert/remove and first-match search, kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command word: kind, position, ident_key, name_key. It is taken on a
//   rising edge with start high and busy low. While busy is high the block
//   walks the record RAM and takes no command.
//   Result word: status, found_position, found_ident, found_name,
//   entry_count. It shows for exactly one cycle with done high; the
//   receiver cannot hold it off, so it must sample it on that edge.
//   Report count, rejects, a remove of the last record and a find on an
//   empty list finish straight out of idle; an append at count+1 only
//   writes the new record; other inserts and removes first shift the
//   records behind the given position, and a find walks up from position
//   1 until a hit or the last record. The rate is set by the single RAM
//   port pair: shifting moves one record per cycle (read one address,
//   write the record read the cycle before), and searching compares one
//   record per cycle against the registered read data.
//   A new command may be given in the cycle that done is high.
//   Reset (rst, synchronous) empties the list; RAM contents are not
//   cleared, as no entry at or past the record count is ever reported.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_search #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [olist_pkg::KIND_W-1:0]     kind,
  input  logic [olist_pkg::POS_W-1:0]      position,
  input  logic [olist_pkg::KEY_W-1:0]      ident_key,
  input  logic [olist_pkg::KEY_W-1:0]      name_key,
  output logic                             done,
  output logic [olist_pkg::STAT_W-1:0]     status,
  output logic [olist_pkg::POS_W-1:0]      found_position,
  output logic [olist_pkg::KEY_W-1:0]      found_ident,
  output logic [olist_pkg::KEY_W-1:0]      found_name,
  output logic [olist_pkg::CNT_W-1:0]      entry_count
);
  import olist_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // RAM address
  localparam int CW = $clog2(DEPTH + 1);                 // record count
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;   // position compares
  localparam int RW = 2 * KEY_BITS;                      // {ident, name}

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,   // move one record per cycle
    S_DRAIN,   // last pending shift write
    S_PUT,     // write the new record
    S_FIND     // compare one record per cycle
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;       // next read address
  logic [CW-1:0]       lo;        // insert slot (position - 1)
  logic [CW-1:0]       cmp_idx;   // address of record in rd_data
  logic [AW-1:0]       wr_addr;   // target of pending shift write
  logic                pend;      // rd_data holds a record in flight
  logic                ins;       // shift direction: up for insert
  logic                by_name;
  logic [KEY_BITS-1:0] id_r;
  logic [KEY_BITS-1:0] nm_r;

  // record RAM: one write port, one registered read port
  logic [RW-1:0]       mem [DEPTH];
  logic [RW-1:0]       rd_data;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [RW-1:0]       wdata;
  logic [AW-1:0]       raddr;

  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;
  logic [KEY_BITS-1:0] rd_ident;
  logic [KEY_BITS-1:0] rd_name;
  logic                hit;

  assign busy    = (state != S_IDLE);
  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(count);
  assign raddr   = ptr[AW-1:0];

  assign rd_ident = rd_data[RW-1:KEY_BITS];
  assign rd_name  = rd_data[KEY_BITS-1:0];
  assign hit      = by_name ? (rd_name == nm_r) : (rd_ident == id_r);

  // RAM write source
  always_comb begin
    we    = 1'b0;
    waddr = wr_addr;
    wdata = rd_data;
    unique case (state)
      S_SHIFT: we = pend;
      S_DRAIN: we = 1'b1;
      S_PUT: begin
        we    = 1'b1;
        waddr = lo[AW-1:0];
        wdata = {id_r, nm_r};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            // defaults for every reply out of idle
            status         <= STAT_DONE;
            found_position <= '0;
            found_ident    <= '0;
            found_name     <= '0;
            entry_count    <= CNT_W'(count);
            pend           <= 1'b0;
            id_r           <= ident_key[KEY_BITS-1:0];
            nm_r           <= name_key[KEY_BITS-1:0];
            unique case (kind)
              KIND_INSERT: begin
                if (count == CW'(DEPTH) || pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                  status <= STAT_REJECT;
                  done   <= 1'b1;
                end else begin
                  lo  <= CW'(pos_ext - 1'b1);
                  ins <= 1'b1;
                  ptr <= count - 1'b1;
                  if (pos_ext - 1'b1 == cnt_ext) begin
                    state <= S_PUT;
                  end else begin
                    state <= S_SHIFT;
                  end
                end
              end
              KIND_REMOVE: begin
                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                  status <= STAT_REJECT;
                  done   <= 1'b1;
                end else if (pos_ext == cnt_ext) begin
                  count       <= count - 1'b1;
                  entry_count <= CNT_W'(count - 1'b1);
                  done        <= 1'b1;
                end else begin
                  ins   <= 1'b0;
                  ptr   <= CW'(pos_ext);
                  state <= S_SHIFT;
                end
              end
              KIND_FIND_NAME, KIND_FIND_IDENT: begin
                by_name <= (kind == KIND_FIND_NAME);
                if (count == '0) begin
                  status <= STAT_MISS;
                  done   <= 1'b1;
                end else begin
                  ptr   <= '0;
                  state <= S_FIND;
                end
              end
              default: begin
                done <= 1'b1;   // report count, and unused kinds
              end
            endcase
          end
        end

        S_SHIFT: begin
          pend <= 1'b1;
          if (ins) begin
            wr_addr <= AW'(ptr + 1'b1);
            if (ptr == lo) begin
              state <= S_DRAIN;
            end else begin
              ptr <= ptr - 1'b1;
            end
          end else begin
            wr_addr <= AW'(ptr - 1'b1);
            if (ptr == count - 1'b1) begin
              state <= S_DRAIN;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end

        S_DRAIN: begin
          pend <= 1'b0;
          if (ins) begin
            state <= S_PUT;
          end else begin
            count       <= count - 1'b1;
            entry_count <= CNT_W'(count - 1'b1);
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end

        S_PUT: begin
          count       <= count + 1'b1;
          entry_count <= CNT_W'(count + 1'b1);
          done        <= 1'b1;
          state       <= S_IDLE;
        end

        S_FIND: begin
          if (pend && hit) begin
            status         <= STAT_FOUND;
            found_position <= POS_W'(cmp_idx + 1'b1);
            found_ident    <= KEY_W'(rd_ident);
            found_name     <= KEY_W'(rd_name);
            done           <= 1'b1;
            pend           <= 1'b0;
            state          <= S_IDLE;
          end else if (pend && cmp_idx == count - 1'b1) begin
            status <= STAT_MISS;
            done   <= 1'b1;
            pend   <= 1'b0;
            state  <= S_IDLE;
          end else begin
            pend    <= 1'b1;
            cmp_idx <= ptr;
            ptr     <= ptr + 1'b1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only appears once the walk is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("record count above DEPTH");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_INSERT && count == CW'(DEPTH))
      |=> (done && status == STAT_REJECT))
    else $error("insert into full list not rejected");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("record count moved by more than one");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_FOUND) |->
      (found_position == '0 && found_ident == '0 && found_name == '0))
    else $error("nonzero match fields without a hit");
`endif

endmodule

>>> test/ordered_list_insert_remove_search_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search_tb
// Self-checking bench for the ordered record list. Command words go in on
// the start/busy handshake. Each one is run through a shadow copy of the
// list, and every done word is compared field by field with the oldest
// pending prediction. The run has directed corner cases on an empty and a
// small list, a fill to full and a drain back to empty, and random traffic
// that swings the list between empty and full under three sender idle rates.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  localparam int DEPTH       = 64;
  localparam int KEY_BITS    = 64;
  localparam int POOL_SIZE   = 8;
  localparam int STALL_LIMIT = 2000;        // longest command walk plus sender gap
  localparam int DRAIN_WAIT  = DEPTH + 8;   // quiet time after the last result

  localparam logic [KEY_W-1:0]  KEY_MASK       = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  // kinds with no operation of their own; the block treats them as report count
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [KEY_W-1:0]  ident;
    logic [KEY_W-1:0]  name;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  fpos;
    logic [KEY_W-1:0]  fident;
    logic [KEY_W-1:0]  fname;
    logic [CNT_W-1:0]  count;
  } list_reply_t;

  // DUT ports
  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [KEY_W-1:0]  ident_key;
  logic [KEY_W-1:0]  name_key;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  found_position;
  logic [KEY_W-1:0]  found_ident;
  logic [KEY_W-1:0]  found_name;
  logic [CNT_W-1:0]  entry_count;

  // shadow copy of the list, advanced at each accepted command word
  logic [KEY_W-1:0] shadow_ident [DEPTH];
  logic [KEY_W-1:0] shadow_name  [DEPTH];
  int               shadow_count;

  list_reply_t      pending_replies [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned gap_pct;          // sender idle chance per cycle, in percent
  bit          growing = 1'b1;   // random traffic heads toward full, else empty
  int          failures;
  int          quiet_cycles;
  int          n_words, n_reject, n_found, n_miss, n_at_full;

  ordered_list_insert_remove_search #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .position       (position),
    .ident_key      (ident_key),
    .name_key       (name_key),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .found_ident    (found_ident),
    .found_name     (found_name),
    .entry_count    (entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow list: applies one command word and returns the result word it owes.
  // Only entries below the count are ever read.
  // --------------------------------------------------------------------------
  function automatic list_reply_t apply_list_op(input list_cmd_t c);
    list_reply_t      r;
    logic [KEY_W-1:0] id_k;
    logic [KEY_W-1:0] nm_k;
    logic [KEY_W-1:0] have;
    int               p;
    int               i;
    r    = '0;
    id_k = c.ident & KEY_MASK;
    nm_k = c.name & KEY_MASK;
    p    = int'(c.pos);
    case (c.kind)
      KIND_INSERT: begin
        // full list, position 0, or a gap past the tail: nothing moves
        if (shadow_count >= DEPTH || p < 1 || p > shadow_count + 1) begin
          r.status = STAT_REJECT;
        end else begin
          for (i = shadow_count; i >= p; i--) begin
            shadow_ident[i] = shadow_ident[i-1];
            shadow_name[i]  = shadow_name[i-1];
          end
          shadow_ident[p-1] = id_k;
          shadow_name[p-1]  = nm_k;
          shadow_count++;
          r.status = STAT_DONE;
        end
      end
      KIND_REMOVE: begin
        if (p < 1 || p > shadow_count) begin
          r.status = STAT_REJECT;
        end else begin
          for (i = p; i < shadow_count; i++) begin
            shadow_ident[i-1] = shadow_ident[i];
            shadow_name[i-1]  = shadow_name[i];
          end
          shadow_count--;
          r.status = STAT_DONE;
        end
      end
      KIND_FIND_NAME, KIND_FIND_IDENT: begin
        // lowest matching position wins
        r.status = STAT_MISS;
        for (i = 0; i < shadow_count; i++) begin
          have = (c.kind == KIND_FIND_NAME) ? shadow_name[i] : shadow_ident[i];
          if (r.status == STAT_MISS && have == ((c.kind == KIND_FIND_NAME) ? nm_k : id_k)) begin
            r.status = STAT_FOUND;
            r.fpos   = POS_W'(i + 1);
            r.fident = shadow_ident[i];
            r.fname  = shadow_name[i];
          end
        end
      end
      default: r.status = STAT_DONE;   // report count and the spare kinds
    endcase
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic list_cmd_t cmd(input logic [KIND_W-1:0] k, input int p,
                                    input logic [KEY_W-1:0] id, input logic [KEY_W-1:0] nm);
    list_cmd_t c;
    c.kind  = k;
    c.pos   = POS_W'(p);
    c.ident = id;
    c.name  = nm;
    return c;
  endfunction

  // half from a small pool (duplicates, zero, all ones), half fresh
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(1) == 0) return key_pool[$urandom_range(POOL_SIZE-1)];
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the word until start && !busy.
  // Inputs change only at the falling edge; start stays high into the next
  // word when there is no gap.
  // --------------------------------------------------------------------------
  task automatic issue_word(input list_cmd_t c);
    list_reply_t r;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start     = 1'b1;
    kind      = c.kind;
    position  = c.pos;
    ident_key = c.ident;
    name_key  = c.name;
    do @(posedge clk); while (busy);
    r = apply_list_op(c);
    pending_replies.push_back(r);
    n_words++;
    if (r.status == STAT_REJECT) n_reject++;
    if (r.status == STAT_FOUND)  n_found++;
    if (r.status == STAT_MISS)   n_miss++;
    if (shadow_count == DEPTH)   n_at_full++;
  endtask

  // sender goes quiet until every owed result word has come back
  task automatic drain_replies();
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: done words must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result word with no command pending: status %0d count %0d",
               status, entry_count);
        failures++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
        if (found_position !== want.fpos) begin
          $error("found_position: expected %0d, got %0d", want.fpos, found_position);
          failures++;
        end
        if (found_ident !== want.fident) begin
          $error("found_ident: expected %h, got %h", want.fident, found_ident);
          failures++;
        end
        if (found_name !== want.fname) begin
          $error("found_name: expected %h, got %h", want.fname, found_name);
          failures++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          failures++;
        end
      end
    end
  end

  // watchdog: too long with neither a command nor a result taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // everything on an empty list: misses, rejects, count, spare kinds
  task automatic test_empty_list();
    issue_word(cmd(KIND_COUNT,      0, '0, '0));
    issue_word(cmd(KIND_FIND_NAME,  0, '0, '0));
    issue_word(cmd(KIND_FIND_IDENT, 0, '0, '0));
    issue_word(cmd(KIND_REMOVE,     1, '0, '0));
    issue_word(cmd(KIND_REMOVE,     0, '0, '0));
    issue_word(cmd(KIND_INSERT,     0, '1, '1));
    issue_word(cmd(KIND_INSERT,     2, '1, '1));
    issue_word(cmd(KIND_SPARE_LO, 127, '1, '1));
    issue_word(cmd(KIND_SPARE_HI,  64, '0, '0));
  endtask

  // front / middle / tail edits, key extremes, duplicate names, bad positions
  task automatic test_small_list_edits();
    logic [KEY_W-1:0] a_nm;
    a_nm = 64'hA5A5_0000_FFFF_1234;
    issue_word(cmd(KIND_INSERT, 1, 64'h0000_0000_0000_00A1, a_nm));
    issue_word(cmd(KIND_INSERT, 1, 64'h0000_0000_0000_00B2, 64'h8000_0000_0000_0001));
    issue_word(cmd(KIND_INSERT, 3, 64'h0000_0000_0000_00C3, 64'h0123_4567_89AB_CDEF));
    issue_word(cmd(KIND_INSERT, 2, 64'h0000_0000_0000_00D4, a_nm));    // same name as A
    issue_word(cmd(KIND_INSERT, 5, '1, '1));
    issue_word(cmd(KIND_INSERT, 1, '0, '0));
    issue_word(cmd(KIND_INSERT, 8, 64'h1, 64'h1));                    // past count+1
    issue_word(cmd(KIND_INSERT, 127, 64'h1, 64'h1));
    issue_word(cmd(KIND_FIND_NAME,  0, '0, a_nm));                    // lowest of two
    issue_word(cmd(KIND_FIND_IDENT, 0, '1, '0));                      // tail hit
    issue_word(cmd(KIND_FIND_IDENT, 0, '0, '1));                      // head hit
    issue_word(cmd(KIND_FIND_IDENT, 0, 64'hDEAD_BEEF_0BAD_F00D, '0)); // miss
    issue_word(cmd(KIND_REMOVE, 0, '0, '0));
    issue_word(cmd(KIND_REMOVE, 7, '0, '0));                          // past count
    issue_word(cmd(KIND_REMOVE, 3, '0, '0));                          // duplicate goes
    issue_word(cmd(KIND_FIND_NAME,  0, '0, a_nm));
    issue_word(cmd(KIND_REMOVE, 1, '0, '0));
    issue_word(cmd(KIND_REMOVE, 4, '0, '0));                          // last record
    issue_word(cmd(KIND_COUNT, 0, '0, '0));
  endtask

  // fill to DEPTH, poke the full list, then drain with mostly front removes
  task automatic test_full_list();
    int sel;
    while (shadow_count < DEPTH) begin
      sel = $urandom_range(2);
      issue_word(cmd(KIND_INSERT,
                     (sel == 0) ? 1 : (sel == 1) ? shadow_count + 1
                                                 : int'($urandom_range(shadow_count + 1, 1)),
                     pick_key(), pick_key()));
    end
    issue_word(cmd(KIND_INSERT, 1, pick_key(), pick_key()));
    issue_word(cmd(KIND_INSERT, DEPTH + 1, pick_key(), pick_key()));
    issue_word(cmd(KIND_COUNT, 0, '0, '0));
    issue_word(cmd(KIND_FIND_IDENT, 0, shadow_ident[DEPTH-1], '0));
    issue_word(cmd(KIND_FIND_NAME, 0, '0, {$urandom, $urandom}));     // walk all, likely miss
    issue_word(cmd(KIND_REMOVE, DEPTH + 1, '0, '0));
    while (shadow_count > 0) begin
      issue_word(cmd(KIND_REMOVE,
                     ($urandom_range(3) != 0) ? 1 : int'($urandom_range(shadow_count, 1)),
                     pick_key(), pick_key()));
    end
  endtask

  // random traffic; inserts dominate while growing, removes while shrinking,
  // so the list keeps sweeping between empty and full
  task automatic test_random_traffic(input int n_items);
    list_cmd_t   c;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned rem_pct;
    int          idx;
    repeat (n_items) begin
      if (shadow_count == DEPTH) growing = 1'b0;
      else if (shadow_count == 0) growing = 1'b1;
      ins_pct = growing ? 55 : 15;
      rem_pct = growing ? 15 : 55;
      c = cmd(KIND_COUNT, int'($urandom_range(127)), pick_key(), pick_key());
      roll = $urandom_range(99);
      if (roll < ins_pct) begin
        c.kind = KIND_INSERT;
        if ($urandom_range(99) < 85) c.pos = POS_W'($urandom_range(shadow_count + 1, 1));
      end else if (roll < ins_pct + rem_pct) begin
        c.kind = KIND_REMOVE;
        if (shadow_count > 0 && $urandom_range(99) < 85)
          c.pos = POS_W'($urandom_range(shadow_count, 1));
      end else if (roll < ins_pct + rem_pct + 24) begin
        c.kind = (roll % 2 == 0) ? KIND_FIND_NAME : KIND_FIND_IDENT;
        // mostly search for a key that is held somewhere in the list
        if (shadow_count > 0 && $urandom_range(99) < 70) begin
          idx     = $urandom_range(shadow_count - 1);
          c.name  = shadow_name[idx];
          c.ident = shadow_ident[idx];
        end
      end else if (roll >= 98) begin
        c.kind = KIND_W'(KIND_FIND_NAME + $urandom_range(KIND_SPARE_HI - KIND_FIND_NAME));
        if (c.kind < KIND_SPARE_LO) c.kind = KIND_SPARE_LO;
      end
      issue_word(c);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    kind      = '0;
    position  = '0;
    ident_key = '0;
    name_key  = '0;
    gap_pct   = 17;
    failures  = 0;
    shadow_count = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_small_list_edits();
    drain_replies();               // sender holds off until all words are back
    test_full_list();
    test_random_traffic(390);
    drain_replies();
    gap_pct = 48;
    test_random_traffic(390);
    drain_replies();
    gap_pct = 0;                   // back-to-back words
    test_random_traffic(390);

    drain_replies();
    repeat (DRAIN_WAIT) @(posedge clk);   // nothing stray may follow
    if (pending_replies.size() != 0) failures++;

    $display("Ran %0d command words: %0d rejected, %0d finds hit, %0d finds missed,",
             n_words, n_reject, n_found, n_miss);
    $display("%0d words left the list full; sender idle at 17, 48 and 0 percent.",
             n_at_full);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
